@@ hdl/lcp_pkg.sv @@
`timescale 1ns / 1ps
package lcp_pkg;

    localparam int CW      = 32;             // coordinate width
    localparam int FB      = 16;             // fraction bits
    localparam int DW      = 48;             // distance width
    localparam int LIMB    = 32;             // multiplier limb width
    localparam int WW      = 168;            // width of the exact wide products
    localparam int DEN_W   = 128;            // width of a divisor
    localparam int IN_W    = 12 * CW;        // request data width
    localparam int OUT_W   = 6 * CW + DW;    // result data width
    localparam int QB      = CW + 2;         // quotient bits kept by the divider
    localparam int OFF_W   = CW + 3;         // clamped offset width
    localparam int DIV_LAT = QB + 4;         // divider latency
    localparam int PRE_STG = 10;             // stages ahead of the dividers
    localparam int POST_STG = 4;             // stages after the dividers
    localparam int THR_SH  = 3 * FB;
    localparam logic [31:0] THR_RESET = 32'd16;

    // Fields of a request.
    localparam int F_OA = 0;
    localparam int F_DA = 1;
    localparam int F_OB = 2;
    localparam int F_DB = 3;

    // Dot products.
    localparam int DOT_A = 0;
    localparam int DOT_B = 1;
    localparam int DOT_C = 2;
    localparam int DOT_D = 3;
    localparam int DOT_E = 4;

    // Products of dot products.
    localparam int PR_AC = 0;
    localparam int PR_BB = 1;
    localparam int PR_BE = 2;
    localparam int PR_CD = 3;
    localparam int PR_AE = 4;
    localparam int PR_BD = 5;
    localparam int PR_LHS [6] = '{DOT_A, DOT_B, DOT_B, DOT_C, DOT_A, DOT_B};
    localparam int PR_RHS [6] = '{DOT_C, DOT_B, DOT_E, DOT_D, DOT_E, DOT_D};

    // Lines.
    localparam int LN1 = 0;
    localparam int LN2 = 1;

    typedef logic signed [CW-1:0]        coord_t;
    typedef logic signed [CW:0]          ext_t;
    typedef logic signed [2*LIMB+1:0]    pp_t;
    typedef logic signed [2*CW+3:0]      dot_t;
    typedef logic signed [WW-1:0]        wide_t;
    typedef logic        [DEN_W-1:0]     den_t;

    typedef struct packed {
        logic [IN_W-1:0] geo;
        logic            par;
        logic            deg;
    } side_t;

    function automatic coord_t geo_coord(input logic [IN_W-1:0] g, input int unsigned f,
                                         input int unsigned j);
        return coord_t'(g[(3*f+j)*CW +: CW]);
    endfunction

    function automatic ext_t ext33(input coord_t x);
        return {x[CW-1], x};
    endfunction

    // One limb of a wide value; only the top limb carries the sign.
    function automatic logic signed [LIMB:0] limb(input wide_t x, input int unsigned k,
                                                  input logic top);
        logic [LIMB-1:0] raw;
        raw = x[LIMB*k +: LIMB];
        return top ? {raw[LIMB-1], raw} : {1'b0, raw};
    endfunction

    function automatic wide_t place(input pp_t p, input int unsigned k);
        wide_t x;
        x = {{(WW-2*LIMB-2){p[2*LIMB+1]}}, p};
        return x << (LIMB*k);
    endfunction

    function automatic coord_t sat_coord(input logic signed [CW+3:0] x);
        logic [4:0] top;
        top = x[CW+3:CW-1];
        if (&top || ~|top) return x[CW-1:0];
        return x[CW+3] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

endpackage

@@ hdl/lcp_div.sv @@
`timescale 1ns / 1ps
module lcp_div
    import lcp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  wide_t                   num,
    input  den_t                    den,
    output logic signed [OFF_W-1:0] off
);

    logic              neg_a_reg, neg_b_reg;
    logic [WW-1:0]     mag_a_reg, n_b_reg;
    den_t              den_a_reg;
    logic [DEN_W:0]    d_b_reg;

    logic [WW-1:0]     r_reg   [0:QB];
    logic [QB-1:0]     q_reg   [0:QB];
    logic [DEN_W:0]    d_reg   [0:QB];
    logic              neg_reg [0:QB];
    logic              ovf_reg [0:QB];

    logic [OFF_W-1:0]  mg;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_a_reg <= num[WW-1];
            mag_a_reg <= num[WW-1] ? -num : num;
            den_a_reg <= den;
            // Rounding half away from zero: floor((2|n| + d) / 2d).
            neg_b_reg <= neg_a_reg;
            n_b_reg   <= {mag_a_reg[WW-2:0], 1'b0} + WW'(den_a_reg);
            d_b_reg   <= {den_a_reg, 1'b0};
            r_reg[0]   <= n_b_reg;
            q_reg[0]   <= '0;
            d_reg[0]   <= d_b_reg;
            neg_reg[0] <= neg_b_reg;
            ovf_reg[0] <= (n_b_reg >> QB) >= WW'(d_b_reg);
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_step
        localparam int SH = QB - 1 - g;
        logic [WW-1:0] dsh;
        assign dsh = WW'(d_reg[g]) << SH;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (r_reg[g] >= dsh) begin
                    r_reg[g+1] <= r_reg[g] - dsh;
                    q_reg[g+1] <= q_reg[g] | (QB'(1) << SH);
                end else begin
                    r_reg[g+1] <= r_reg[g];
                    q_reg[g+1] <= q_reg[g];
                end
                d_reg[g+1]   <= d_reg[g];
                neg_reg[g+1] <= neg_reg[g];
                ovf_reg[g+1] <= ovf_reg[g];
            end
        end
    end

    // Magnitudes of 2^(CW+1) and above clamp to 2^(CW+1).
    always_comb begin
        if (ovf_reg[QB] || q_reg[QB][QB-1]) mg = OFF_W'(1) << (CW + 1);
        else mg = {1'b0, q_reg[QB]};
    end

    always_ff @(posedge aclk) begin
        if (en) off <= neg_reg[QB] ? -mg : mg;
    end

endmodule

@@ hdl/line_to_line_closest_points.sv @@
`timescale 1ns / 1ps
// Closest points between two 3D lines in signed Q16.16.
// A request on the s_ channel carries both lines (origin and direction each);
// the m_ channel returns both closest points, their squared distance in
// Q32.16 and the parallel and degenerate flags in m_tuser.
// The user must write the parallel threshold through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block leaves this to the user. Reset sets the threshold to 16.
// The datapath is a 52-stage pipeline: ten stages of dot products and
// limb-split multiplies, a 38-stage restoring divider (one quotient bit per
// step stage, six dividers side by side), and four stages of point and distance
// arithmetic. One request is accepted every cycle while s_tready is high.
// The output register has a one-entry skid stage behind it: when the
// receiver stalls, the skid entry fills and the whole pipeline then holds,
// with s_tready low, until the receiver takes a result.
// Reset empties the pipeline and both output entries.
module line_to_line_closest_points
    import lcp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // a_origin_x/y/z, a_dir_x/y/z, b_origin_x/y/z, b_dir_x/y/z, 32 bits each
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // p1_x/y/z, p2_x/y/z (32 bits each), dist_sq (48 bits)
    output logic [OUT_W-1:0] m_tdata,
    // is_parallel, is_degenerate
    output logic [1:0]       m_tuser
);

    localparam int NSTG = PRE_STG + DIV_LAT + POST_STG;

    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [31:0]     thr_reg;

    logic [IN_W-1:0] geo_reg [1:PRE_STG];
    logic signed [CW:0] w0_reg [3];
    pp_t             pr_reg  [5][3];
    dot_t            dot_reg [5];
    dot_t            ce_reg  [4:7][2];
    pp_t             pp_reg  [6][3][3];
    wide_t           row_reg [6][3];
    wide_t           prod_reg [6];
    den_t            denom7_reg;
    wide_t           s7_reg, t7_reg;
    logic            deg7_reg;
    wide_t           num8_reg [2];
    den_t            den8_reg [2], den9_reg [2], den10_reg [2];
    logic            par8_reg, par9_reg, par10_reg;
    logic            deg8_reg, deg9_reg, deg10_reg;
    pp_t             npp_reg  [2][3][5];
    wide_t           nprod_reg [2][3];
    wide_t           dif_denom, dif_s, dif_t;
    logic            par_now;

    logic signed [OFF_W-1:0] off_w [2][3];
    side_t           sd_reg [1:DIV_LAT];

    logic [6*CW-1:0] pts_next;
    logic [6*CW-1:0] pts_reg [0:POST_STG-1];
    logic            par_reg [0:POST_STG-1];
    logic            deg_reg [0:POST_STG-1];
    logic signed [CW:0]      df_reg [3];
    pp_t             sq_reg [3];
    logic [2*CW+3:0] tot;
    logic [DW-1:0]   dist_reg;

    logic [OUT_W+1:0] last_data, out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Stages 1 to 3: w0 = Oa - Ob, the fifteen products, the five dot products.
    always_ff @(posedge aclk) begin
        if (en) begin
            geo_reg[1] <= s_tdata;
            for (int k = 2; k <= PRE_STG; k++) geo_reg[k] <= geo_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                w0_reg[i] <= ext33(geo_coord(s_tdata, F_OA, i)) -
                             ext33(geo_coord(s_tdata, F_OB, i));
                pr_reg[DOT_A][i] <= ext33(geo_coord(geo_reg[1], F_DA, i)) *
                                    ext33(geo_coord(geo_reg[1], F_DA, i));
                pr_reg[DOT_B][i] <= ext33(geo_coord(geo_reg[1], F_DA, i)) *
                                    ext33(geo_coord(geo_reg[1], F_DB, i));
                pr_reg[DOT_C][i] <= ext33(geo_coord(geo_reg[1], F_DB, i)) *
                                    ext33(geo_coord(geo_reg[1], F_DB, i));
                pr_reg[DOT_D][i] <= ext33(geo_coord(geo_reg[1], F_DA, i)) * w0_reg[i];
                pr_reg[DOT_E][i] <= ext33(geo_coord(geo_reg[1], F_DB, i)) * w0_reg[i];
            end
            for (int k = 0; k < 5; k++) begin
                dot_reg[k] <= dot_t'(pr_reg[k][0]) + dot_t'(pr_reg[k][1]) +
                              dot_t'(pr_reg[k][2]);
            end
        end
    end

    // Stages 4 to 6: the six wide products as 3x3 limb products, row sums, totals.
    always_ff @(posedge aclk) begin
        if (en) begin
            ce_reg[4][0] <= dot_reg[DOT_C];
            ce_reg[4][1] <= dot_reg[DOT_E];
            for (int k = 5; k <= 7; k++) ce_reg[k] <= ce_reg[k-1];
            for (int p = 0; p < 6; p++) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        pp_reg[p][i][j] <= limb(wide_t'(dot_reg[PR_LHS[p]]), i, i == 2) *
                                           limb(wide_t'(dot_reg[PR_RHS[p]]), j, j == 2);
                    end
                    row_reg[p][i] <= place(pp_reg[p][i][0], i) +
                                     place(pp_reg[p][i][1], i + 1) +
                                     place(pp_reg[p][i][2], i + 2);
                end
                prod_reg[p] <= row_reg[p][0] + row_reg[p][1] + row_reg[p][2];
            end
        end
    end

    assign dif_denom = prod_reg[PR_AC] - prod_reg[PR_BB];
    assign dif_s     = prod_reg[PR_BE] - prod_reg[PR_CD];
    assign dif_t     = prod_reg[PR_AE] - prod_reg[PR_BD];
    assign par_now   = deg7_reg || (denom7_reg <= (DEN_W'(thr_reg) << THR_SH));

    // Stages 7 to 10: denom, s and t; the parallel decision; numerator times
    // direction in five limbs, then their sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            denom7_reg <= dif_denom[DEN_W-1:0];
            s7_reg     <= dif_s;
            t7_reg     <= dif_t;
            deg7_reg   <= (ce_reg[6][0] == '0);

            par8_reg       <= par_now;
            deg8_reg       <= deg7_reg;
            num8_reg[LN1]  <= s7_reg;
            den8_reg[LN1]  <= denom7_reg;
            num8_reg[LN2]  <= par_now ? wide_t'(ce_reg[7][1]) : t7_reg;
            den8_reg[LN2]  <= par_now ? DEN_W'(ce_reg[7][0][2*CW-1:0]) : denom7_reg;

            par9_reg  <= par8_reg;
            deg9_reg  <= deg8_reg;
            den9_reg  <= den8_reg;
            par10_reg <= par9_reg;
            deg10_reg <= deg9_reg;
            den10_reg <= den9_reg;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 5; k++) begin
                    npp_reg[LN1][i][k] <= limb(num8_reg[LN1], k, k == 4) *
                                          ext33(geo_coord(geo_reg[8], F_DA, i));
                    npp_reg[LN2][i][k] <= limb(num8_reg[LN2], k, k == 4) *
                                          ext33(geo_coord(geo_reg[8], F_DB, i));
                end
                for (int l = 0; l < 2; l++) begin
                    nprod_reg[l][i] <= place(npp_reg[l][i][0], 0) +
                                       place(npp_reg[l][i][1], 1) +
                                       place(npp_reg[l][i][2], 2) +
                                       place(npp_reg[l][i][3], 3) +
                                       place(npp_reg[l][i][4], 4);
                end
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_line
        for (genvar i = 0; i < 3; i++) begin : g_axis
            lcp_div u_div (
                .aclk (aclk),
                .en   (en),
                .num  (nprod_reg[l][i]),
                .den  (den10_reg[l]),
                .off  (off_w[l][i])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[1] <= '{geo: geo_reg[PRE_STG], par: par10_reg, deg: deg10_reg};
            for (int k = 2; k <= DIV_LAT; k++) sd_reg[k] <= sd_reg[k-1];
        end
    end

    always_comb begin
        pts_next = '0;
        for (int i = 0; i < 3; i++) begin
            pts_next[i*CW +: CW] = sd_reg[DIV_LAT].par ?
                geo_coord(sd_reg[DIV_LAT].geo, F_OA, i) :
                sat_coord((CW+4)'(geo_coord(sd_reg[DIV_LAT].geo, F_OA, i)) +
                          (CW+4)'(off_w[LN1][i]));
            pts_next[(3+i)*CW +: CW] = sd_reg[DIV_LAT].deg ?
                geo_coord(sd_reg[DIV_LAT].geo, F_OB, i) :
                sat_coord((CW+4)'(geo_coord(sd_reg[DIV_LAT].geo, F_OB, i)) +
                          (CW+4)'(off_w[LN2][i]));
        end
    end

    assign tot = (2*CW+4)'(sq_reg[0]) + (2*CW+4)'(sq_reg[1]) + (2*CW+4)'(sq_reg[2]) +
                 ((2*CW+4)'(1) << (FB - 1));

    // Points, differences, squares, then the rounded and saturated distance.
    always_ff @(posedge aclk) begin
        if (en) begin
            pts_reg[0] <= pts_next;
            par_reg[0] <= sd_reg[DIV_LAT].par;
            deg_reg[0] <= sd_reg[DIV_LAT].deg;
            for (int k = 1; k < POST_STG; k++) begin
                pts_reg[k] <= pts_reg[k-1];
                par_reg[k] <= par_reg[k-1];
                deg_reg[k] <= deg_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                df_reg[i] <= ext33(coord_t'(pts_reg[0][i*CW +: CW])) -
                             ext33(coord_t'(pts_reg[0][(3+i)*CW +: CW]));
                sq_reg[i] <= df_reg[i] * df_reg[i];
            end
            if (|tot[2*CW+3:FB+DW]) dist_reg <= '1;
            else dist_reg <= tot[FB+DW-1:FB];
        end
    end

    assign last_data = {deg_reg[POST_STG-1], par_reg[POST_STG-1], dist_reg,
                        pts_reg[POST_STG-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= vld_reg[NSTG-1];
            end
        end else if (vld_reg[NSTG-1] && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : last_data;
        end else if (en) begin
            skid_reg <= last_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[OUT_W-1:0];
    assign m_tuser  = out_reg[OUT_W+1:OUT_W];

endmodule

@@ verif/tb_line_to_line_closest_points.sv @@
`timescale 1ns / 1ps
module tb_line_to_line_closest_points;
    import lcp_pkg::*;

    localparam int N_SEG       = 4;
    localparam int SEG_ITEMS   = 410;
    localparam int DRAIN_CYC   = 70;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYC    = 400;

    typedef logic signed [255:0] big_t;
    typedef struct packed {
        logic [OUT_W-1:0] pts;
        logic [1:0]       flags;
    } closest_t;

    class closest_pt_scoreboard;
        logic [31:0] threshold = THR_RESET;
        closest_t    pending[$];
        int          mismatches;
        int          n_checked;
        int          n_parallel;
        int          n_degenerate;

        // Rounded quotient, halves away from zero, then clamped to +-2^(CW+1).
        function big_t offset(big_t num, big_t den);
            bit [255:0] mag;
            bit [255:0] q;
            big_t       r;
            big_t       lim;
            mag = num < 0 ? -num : num;
            q = ((mag << 1) + den) / (den << 1);
            r = num < 0 ? -big_t'(q) : big_t'(q);
            lim = big_t'(1) <<< (CW + 1);
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function big_t clip_coord(big_t x);
            big_t hi;
            big_t lo;
            hi = (big_t'(1) <<< (CW - 1)) - 1;
            lo = -(big_t'(1) <<< (CW - 1));
            return x > hi ? hi : (x < lo ? lo : x);
        endfunction

        function closest_t closest_points(logic [IN_W-1:0] g);
            big_t     oa[3], da[3], ob[3], db[3], w0[3], p1[3], p2[3];
            big_t     a, b, c, d, e, denom, s, t, sum, df;
            closest_t r;
            logic     par, deg;
            for (int i = 0; i < 3; i++) begin
                oa[i] = big_t'($signed(g[(i)*CW +: CW]));
                da[i] = big_t'($signed(g[(3 + i)*CW +: CW]));
                ob[i] = big_t'($signed(g[(6 + i)*CW +: CW]));
                db[i] = big_t'($signed(g[(9 + i)*CW +: CW]));
                w0[i] = oa[i] - ob[i];
            end
            a = 0; b = 0; c = 0; d = 0; e = 0;
            for (int i = 0; i < 3; i++) begin
                a += da[i] * da[i];
                b += da[i] * db[i];
                c += db[i] * db[i];
                d += da[i] * w0[i];
                e += db[i] * w0[i];
            end
            denom = a * c - b * b;
            par = 0;
            deg = 0;
            if (c == 0) begin
                par = 1;
                deg = 1;
                for (int i = 0; i < 3; i++) begin
                    p1[i] = oa[i];
                    p2[i] = ob[i];
                end
            end else if (denom <= (big_t'(threshold) <<< (3 * FB))) begin
                par = 1;
                for (int i = 0; i < 3; i++) begin
                    p1[i] = oa[i];
                    p2[i] = clip_coord(ob[i] + offset(e * db[i], c));
                end
            end else begin
                s = b * e - c * d;
                t = a * e - b * d;
                for (int i = 0; i < 3; i++) begin
                    p1[i] = clip_coord(oa[i] + offset(s * da[i], denom));
                    p2[i] = clip_coord(ob[i] + offset(t * db[i], denom));
                end
            end
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                df = p1[i] - p2[i];
                sum += df * df;
            end
            sum = (sum + (big_t'(1) <<< (FB - 1))) >>> FB;
            if (sum > ((big_t'(1) <<< DW) - 1)) sum = (big_t'(1) <<< DW) - 1;
            for (int i = 0; i < 3; i++) begin
                r.pts[i*CW +: CW]       = p1[i][CW-1:0];
                r.pts[(3 + i)*CW +: CW] = p2[i][CW-1:0];
            end
            r.pts[6*CW +: DW] = sum[DW-1:0];
            r.flags = {deg, par};
            return r;
        endfunction

        function void note_request(logic [IN_W-1:0] g);
            closest_t r;
            r = closest_points(g);
            n_parallel += r.flags[0];
            n_degenerate += r.flags[1];
            pending.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] pts, logic [1:0] flags);
            closest_t x;
            logic     bad;
            n_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing outstanding: %h / %b", pts, flags);
                return;
            end
            x = pending.pop_front();
            bad = 0;
            for (int f = 0; f < 6; f++)
                if (pts[f*CW +: CW] !== x.pts[f*CW +: CW]) bad = 1;
            if (pts[6*CW +: DW] !== x.pts[6*CW +: DW] || flags !== x.flags) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d mismatch", n_checked);
                    for (int f = 0; f < 6; f++)
                        $display("  coord %0d exp %h got %h", f, x.pts[f*CW +: CW],
                                 pts[f*CW +: CW]);
                    $display("  dist exp %h got %h, flags exp %b got %b",
                             x.pts[6*CW +: DW], pts[6*CW +: DW], x.flags, flags);
                end
            end
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             cfg_wr_en = 0;
    logic [31:0]      cfg_wr_data = '0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    closest_pt_scoreboard sb = new();
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  hold_left;
    int  quiet_cycles;
    int  n_sent;

    always #4 aclk = ~aclk;

    line_to_line_closest_points u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Receiver: random back-pressure, or a long hold while the sender keeps pushing.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL line_to_line_closest_points");
                $finish;
            end
        end
    end

    task automatic send_request(logic [IN_W-1:0] g);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= g;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        sb.threshold = v;
        @(negedge aclk);
    endtask

    function automatic logic [IN_W-1:0] pack_lines(logic [31:0] f[12]);
        logic [IN_W-1:0] g;
        for (int i = 0; i < 12; i++) g[i*CW +: CW] = f[i];
        return g;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(6))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] near(int span_bits);
        return $signed($urandom_range((1 << span_bits) - 1)) - (1 << (span_bits - 1));
    endfunction

    function automatic logic [IN_W-1:0] random_lines();
        logic [31:0] f[12];
        int          k;
        int          kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 12; i++) f[i] = (i % 6 < 3) ? near(22) : near(19);
        case (kind)
            4: for (int i = 0; i < 12; i++) f[i] = $urandom;
            5, 9: begin
                // Second direction is a multiple of the first, nudged a little.
                k = $urandom_range(6) - 3;
                if (k == 0) k = 1;
                for (int i = 0; i < 3; i++) begin
                    if (kind == 9) f[3 + i] = near(28);
                    f[9 + i] = $signed(f[3 + i]) * k + $signed(near(kind == 9 ? 12 : 2));
                end
            end
            6: for (int i = 9; i < 12; i++) f[i] = 0;
            7: for (int i = 3; i < 6; i++) f[i] = 0;
            8: for (int i = 0; i < 12; i++) f[i] = edge_value();
            default: ;
        endcase
        return pack_lines(f);
    endfunction

    task automatic run_directed();
        logic [31:0] f[12];
        localparam logic [31:0] ONE = 32'h0001_0000;
        // Skew lines along x and y, apart in z.
        f = '{0, 0, 0, ONE, 0, 0, 0, 0, 3*ONE, 0, ONE, 0};
        send_request(pack_lines(f));
        f = '{ONE, 2*ONE, -ONE, ONE, ONE, 0, 5*ONE, 0, 0, 0, ONE, ONE};
        send_request(pack_lines(f));
        // Same and opposite directions.
        f = '{0, 0, 0, ONE, ONE, 0, ONE, 0, 0, ONE, ONE, 0};
        send_request(pack_lines(f));
        f = '{0, ONE, 0, ONE, 2*ONE, 3*ONE, 0, 0, ONE, -ONE, -2*ONE, -3*ONE};
        send_request(pack_lines(f));
        // Zero second direction, zero first direction, both zero.
        f = '{ONE, 2*ONE, 3*ONE, ONE, 0, 0, -ONE, 0, 0, 0, 0, 0};
        send_request(pack_lines(f));
        f = '{ONE, 2*ONE, 3*ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 0};
        send_request(pack_lines(f));
        f = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_request(pack_lines(f));
        // Denominator right at the default threshold and one step past it.
        f = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 1024, 0};
        send_request(pack_lines(f));
        f = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 1025, 0};
        send_request(pack_lines(f));
        // Field extremes; some of these saturate the distance.
        for (int i = 0; i < 12; i++) f[i] = 32'h7fff_ffff;
        send_request(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = 32'h8000_0000;
        send_request(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        send_request(pack_lines(f));
        f = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0, 0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 0};
        send_request(pack_lines(f));
        f = '{32'h8000_0000, 0, 32'h7fff_ffff, ONE, ONE, 1,
              32'h7fff_ffff, 0, 32'h8000_0000, 1, -ONE, ONE};
        send_request(pack_lines(f));
        f = '{32'hffff_ffff, 1, 0, 32'h7fff_ffff, 1, 0, 1, 32'hffff_ffff, 0, 32'h7fff_ffff,
              2, 0};
        send_request(pack_lines(f));
        for (int i = 0; i < 12; i++) f[i] = 32'hffff_ffff;
        send_request(pack_lines(f));
    endtask

    initial begin
        tx_idle_pct = 37;
        rx_idle_pct = 51;
        hold_left = 0;
        quiet_cycles = 0;
        n_sent = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        for (int seg = 0; seg < N_SEG; seg++) begin
            case (seg)
                0: run_directed();
                1: begin
                    write_threshold(32'h0);
                    tx_idle_pct = 51;
                    rx_idle_pct = 37;
                end
                2: begin
                    write_threshold(32'hffff_ffff);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_left = HOLD_CYC;
                end
                default: write_threshold($urandom);
            endcase
            for (int n = 0; n < SEG_ITEMS; n++) send_request(random_lines());
            drain_pipeline();
        end
        // Back to the reset threshold so the last phase ends on the default.
        write_threshold(THR_RESET);
        run_directed();
        drain_pipeline();
        $display("Sent %0d line pairs under four thresholds and three back-pressure mixes;",
                 n_sent);
        $display("%0d results checked, %0d parallel, %0d degenerate, %0d mismatches.",
                 sb.n_checked, sb.n_parallel, sb.n_degenerate, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS line_to_line_closest_points");
        end else begin
            $display("FAIL line_to_line_closest_points");
        end
        $finish;
    end

endmodule
